/* hdl/bnv_pkg.sv */
// ----------------------------------------------------------------------------
// bnv_pkg
// Shared types and constants for the bucket name validator.
// ----------------------------------------------------------------------------
package bnv_pkg;

  // Name length limits; the counter saturates one past the maximum
  localparam int unsigned MinNameLen = 3;
  localparam int unsigned MaxNameLen = 63;
  localparam int unsigned LenCap     = 64;
  localparam int unsigned LenW       = $clog2(LenCap + 1);

  // Characters of interest
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;

  // Result codes, in priority order
  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBlank      = 3'd1,
    StTooShort   = 3'd2,
    StTooLong    = 3'd3,
    StIpAddress  = 3'd4,
    StBadPair    = 3'd5,
    StNotStrict  = 3'd6,
    StNotRelaxed = 3'd7
  } status_e;

  // Class of the previous byte, for the forbidden pair check
  typedef enum logic [1:0] {
    ClsDot    = 2'd0,
    ClsHyphen = 2'd1,
    ClsOther  = 2'd2
  } class_e;

endpackage

/* hdl/bnv_if.sv */
// ----------------------------------------------------------------------------
// bnv_if
// Valid/ready channels of the bucket name validator: name bytes, status
// results and the mode register write port.
// ----------------------------------------------------------------------------

// Name byte channel
interface bnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       is_last;

  modport source (output valid, output name_char, output is_last, input ready);
  modport sink   (input valid, input name_char, input is_last, output ready);
endinterface

// Status result channel
interface bnv_out_if;
  logic                  valid;
  logic                  ready;
  bnv_pkg::status_e      status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

// Mode register write channel
interface bnv_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;

  modport source (output valid, output strict_mode, input ready);
  modport sink   (input valid, input strict_mode, output ready);
endinterface

/* hdl/bucket_name_validator.sv */
// ----------------------------------------------------------------------------
// bucket_name_validator
// Checks a bucket name streamed one byte per transfer and reports one
// status code on the last byte.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                 Transfer
// name_i    in   name_char[7:0], is_last  valid && ready
// status_o  out  status[2:0]             valid && ready, one per name
// cfg_i     in   strict_mode             valid && ready, ready always high
//
// One byte per cycle sustained, except that a last byte waits in the input
// register while the result is stalled. When a last byte leaves the input
// register, its status appears in the result register in the next cycle.
// Reset clears all name state and sets strict mode. A stalled result holds
// only a last byte in the input register; other bytes keep flowing.
// ----------------------------------------------------------------------------
module bucket_name_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  bnv_in_if.sink     name_i,
  bnv_out_if.source  status_o,
  bnv_cfg_if.sink    cfg_i
);

  localparam logic [bnv_pkg::LenW-1:0] LenCapV =
    bnv_pkg::LenW'(bnv_pkg::LenCap);
  localparam logic [bnv_pkg::LenW-1:0] MinLenV =
    bnv_pkg::LenW'(bnv_pkg::MinNameLen);
  localparam logic [bnv_pkg::LenW-1:0] MaxLenV =
    bnv_pkg::LenW'(bnv_pkg::MaxNameLen);

  // Mode register
  logic strict_mode_q;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Result register
  logic             out_valid_q;
  bnv_pkg::status_e status_q, status_d;

  // Name state
  logic [bnv_pkg::LenW-1:0] len_q, len_d;
  logic                     blank_q, blank_d;
  bnv_pkg::class_e          prev_q, prev_d;
  logic                     bad_pair_q, bad_pair_d;
  logic                     strict_ok_q, strict_ok_d;
  logic                     relaxed_ok_q, relaxed_ok_d;
  logic                     ip_q, ip_d;
  logic [1:0]               dots_q, dots_d;
  logic [1:0]               digs_q, digs_d;
  logic [7:0]               oval_q, oval_d;
  logic                     lzero_q, lzero_d;

  // Handshake
  logic advance;
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || status_o.ready);
  assign name_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;
  assign status_o.valid  = out_valid_q;
  assign status_o.status = status_q;

  // Character classes of the held byte
  logic is_digit, is_lower, is_upper, is_dot, is_hyph;
  logic end_s, end_r, mid_s, mid_r;
  logic [3:0]  dval;
  logic [11:0] ov_next;

  always_comb begin
    is_digit = (in_char_q >= bnv_pkg::ChZero) && (in_char_q <= bnv_pkg::ChNine);
    is_lower = (in_char_q >= bnv_pkg::ChLowA) && (in_char_q <= bnv_pkg::ChLowZ);
    is_upper = (in_char_q >= bnv_pkg::ChUpA) && (in_char_q <= bnv_pkg::ChUpZ);
    is_dot   = (in_char_q == bnv_pkg::ChDot);
    is_hyph  = (in_char_q == bnv_pkg::ChHyphen);
    end_s    = is_lower || is_digit;
    end_r    = end_s || is_upper;
    mid_s    = end_s || is_dot || is_hyph;
    mid_r    = end_r || is_dot || is_hyph || (in_char_q == bnv_pkg::ChUscore) ||
               (in_char_q == bnv_pkg::ChColon);
    dval     = 4'(in_char_q - bnv_pkg::ChZero);
    // octet * 10 + digit
    ov_next  = {1'b0, oval_q, 3'b000} + {3'b000, oval_q, 1'b0} + {8'h00, dval};
  end

  // Next name state for the held byte
  always_comb begin
    // pattern flags: end rule on first and last byte
    if ((len_q == '0) || in_last_q) begin
      strict_ok_d  = strict_ok_q && end_s;
      relaxed_ok_d = relaxed_ok_q && end_r;
    end else begin
      strict_ok_d  = strict_ok_q && mid_s;
      relaxed_ok_d = relaxed_ok_q && mid_r;
    end

    // dotted-quad tracker
    ip_d    = ip_q;
    dots_d  = dots_q;
    digs_d  = digs_q;
    oval_d  = oval_q;
    lzero_d = lzero_q;
    if (ip_q) begin
      if (is_digit) begin
        if ((digs_q == 2'd3) || ((digs_q != 2'd0) && lzero_q)) begin
          ip_d = 1'b0;
        end else if (ov_next > 12'd255) begin
          ip_d = 1'b0;
        end else begin
          if (digs_q == 2'd0) begin
            lzero_d = (dval == 4'd0);
          end
          oval_d = ov_next[7:0];
          digs_d = digs_q + 2'd1;
        end
      end else if (is_dot) begin
        if ((digs_q == 2'd0) || (dots_q == 2'd3)) begin
          ip_d = 1'b0;
        end else begin
          dots_d  = dots_q + 2'd1;
          digs_d  = 2'd0;
          oval_d  = 8'h00;
          lzero_d = 1'b0;
        end
      end else begin
        ip_d = 1'b0;
      end
    end

    // forbidden pairs
    bad_pair_d = bad_pair_q ||
                 ((prev_q == bnv_pkg::ClsDot) && (is_dot || is_hyph)) ||
                 ((prev_q == bnv_pkg::ClsHyphen) && is_dot);
    prev_d = is_dot ? bnv_pkg::ClsDot : (is_hyph ? bnv_pkg::ClsHyphen : bnv_pkg::ClsOther);

    blank_d = blank_q && (in_char_q == bnv_pkg::ChSpace);
    len_d   = (len_q < LenCapV) ? len_q + 1'b1 : len_q;
  end

  // Status in priority order
  always_comb begin
    if (blank_d) begin
      status_d = bnv_pkg::StBlank;
    end else if (len_d < MinLenV) begin
      status_d = bnv_pkg::StTooShort;
    end else if (len_d > MaxLenV) begin
      status_d = bnv_pkg::StTooLong;
    end else if (ip_d && (dots_d == 2'd3) && (digs_d != 2'd0)) begin
      status_d = bnv_pkg::StIpAddress;
    end else if (bad_pair_d) begin
      status_d = bnv_pkg::StBadPair;
    end else if (strict_mode_q) begin
      status_d = strict_ok_d ? bnv_pkg::StOk : bnv_pkg::StNotStrict;
    end else begin
      status_d = relaxed_ok_d ? bnv_pkg::StOk : bnv_pkg::StNotRelaxed;
    end
  end

  // Control and name state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_mode_q <= 1'b1;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      len_q         <= '0;
      blank_q       <= 1'b1;
      prev_q        <= bnv_pkg::ClsOther;
      bad_pair_q    <= 1'b0;
      strict_ok_q   <= 1'b1;
      relaxed_ok_q  <= 1'b1;
      ip_q          <= 1'b1;
      dots_q        <= 2'd0;
      digs_q        <= 2'd0;
      oval_q        <= 8'h00;
      lzero_q       <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        strict_mode_q <= cfg_i.strict_mode;
      end
      if (name_i.ready) begin
        in_valid_q <= name_i.valid;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (status_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (in_last_q) begin
          // name done: back to the empty-name state
          len_q        <= '0;
          blank_q      <= 1'b1;
          prev_q       <= bnv_pkg::ClsOther;
          bad_pair_q   <= 1'b0;
          strict_ok_q  <= 1'b1;
          relaxed_ok_q <= 1'b1;
          ip_q         <= 1'b1;
          dots_q       <= 2'd0;
          digs_q       <= 2'd0;
          oval_q       <= 8'h00;
          lzero_q      <= 1'b0;
        end else begin
          len_q        <= len_d;
          blank_q      <= blank_d;
          prev_q       <= prev_d;
          bad_pair_q   <= bad_pair_d;
          strict_ok_q  <= strict_ok_d;
          relaxed_ok_q <= relaxed_ok_d;
          ip_q         <= ip_d;
          dots_q       <= dots_d;
          digs_q       <= digs_d;
          oval_q       <= oval_d;
          lzero_q      <= lzero_d;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (name_i.valid && name_i.ready) begin
      in_char_q <= name_i.name_char;
      in_last_q <= name_i.is_last;
    end
    if (advance && in_last_q) begin
      status_q <= status_d;
    end
  end

  // Checks
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenCapV)
    else $error("name length above cap");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (len_q == '0) && blank_q && ip_q && out_valid_q)
    else $error("state not cleared or result missing after last byte");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !name_i.ready |-> (in_valid_q && in_last_q && out_valid_q && !status_o.ready))
    else $error("input stalled without a blocked result");

  a_octet_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ip_q && (digs_q == 2'd0)) |-> (oval_q == 8'h00) && !lzero_q)
    else $error("octet value left over at octet start");

endmodule
